FILE: sv/kmenc_pkg.sv
// ----------------------------------------------------------------------------
// kmenc_pkg
// types and constants for the key edge midi event encoder
// ----------------------------------------------------------------------------
`default_nettype none

package kmenc_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] RegChannel  = 2'd0;
  localparam logic [1:0] RegVelocity = 2'd1;
  localparam logic [1:0] RegCount    = 2'd2;
  localparam logic [1:0] RegBend     = 2'd3;

  // usb-midi code index numbers, cable 0
  localparam logic [7:0] CinOn   = 8'h09;
  localparam logic [7:0] CinOff  = 8'h08;
  localparam logic [7:0] CinBend = 8'h0E;

  // status bytes before the channel is merged in
  localparam logic [7:0] StatusOn   = 8'h90;
  localparam logic [7:0] StatusOff  = 8'h80;
  localparam logic [7:0] StatusBend = 8'hE0;

  localparam logic [13:0] BendCentre = 14'h2000;
  localparam logic [13:0] BendMax    = 14'h3FFF;
  localparam logic [6:0]  SevenBits  = 7'h7F;

  localparam logic [6:0] VelocityReset = 7'd100;

  // fixed width of the key bitmap and maximum depth of the pin tables
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned TableDepth = 32;

  typedef struct packed {
    logic [7:0] d2;
    logic [7:0] d1;
    logic [7:0] status;
    logic [7:0] cin;
  } pkt_t;

endpackage : kmenc_pkg

`default_nettype wire

FILE: sv/key_edge_midi_event_encoder.sv
// ----------------------------------------------------------------------------
// key_edge_midi_event_encoder
// turns key bitmap scans into usb-midi note-on, note-off and pitch-bend items
// ----------------------------------------------------------------------------
//
// channel    dir  handshake                  payload
// s_axis     in   tvalid / tready            tdata: scan or map write, tuser: cmd
// m_axis     out  tvalid / tready            tdata: 4-byte packet, tlast: last of scan
// cfg        in   cfg_we_i, write only       cfg_idx_i selects, cfg_data_i value
//
// map writes and scans while the host is unmounted are taken in idle, which stays ready for more
// a mounted scan walks the pin table at one pin a cycle while m_axis does not stall:
//   min(note_count, pins) pins, then the bend step and the final flush
// the walk is set by the single read port of the pin table memory
// the packet of the current pin waits in a pending slot so the last one can be flagged
// reset sets the control and configuration registers and clears the table valid bits; tables read as zero until written
//
`default_nettype none

module key_edge_midi_event_encoder
  import kmenc_pkg::*;
#(
  parameter int unsigned NUM_PINS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // key_bits[31:0], host_mounted[32], ring_active[33], ring_y[49:34],
  // map_pin[54:50], map_note[61:55], map_velocity[68:62], zero fill [71:69]
  input  wire logic [71:0] s_axis_tdata,
  // cmd[0]
  input  wire logic        s_axis_tuser,
  // master side
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // packet_cin[7:0], packet_status[15:8], packet_data1[23:16], packet_data2[31:24]
  output      logic [31:0] m_axis_tdata,
  output      logic        m_axis_tlast,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_data_i
);

  // pins that have table entries
  localparam int unsigned Depth = (NUM_PINS < TableDepth) ? NUM_PINS : TableDepth;
  localparam int unsigned PinW  = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_BEND  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  // input fields
  logic                cmd;
  logic [31:0]         key_bits;
  logic                host_mounted;
  logic                ring_active;
  logic signed [15:0]  ring_y;
  logic [4:0]          map_pin;
  logic [6:0]          map_note;
  logic [6:0]          map_velocity;

  assign cmd          = s_axis_tuser;
  assign key_bits     = s_axis_tdata[31:0];
  assign host_mounted = s_axis_tdata[32];
  assign ring_active  = s_axis_tdata[33];
  assign ring_y       = s_axis_tdata[49:34];
  assign map_pin      = s_axis_tdata[54:50];
  assign map_note     = s_axis_tdata[61:55];
  assign map_velocity = s_axis_tdata[68:62];

  // configuration registers
  logic [3:0] chan_q;
  logic [6:0] gvel_q;
  logic [5:0] count_q;
  logic       bend_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q    <= '0;
      gvel_q    <= VelocityReset;
      count_q   <= '0;
      bend_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegChannel:  chan_q    <= cfg_data_i[3:0];
        RegVelocity: gvel_q    <= cfg_data_i;
        RegCount:    count_q   <= cfg_data_i[5:0];
        RegBend:     bend_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [1:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] keys_q, keys_d;
  logic [31:0] prev_keys_q, prev_keys_d;
  logic        ring_act_q, ring_act_d;
  logic [15:0] ring_y_q, ring_y_d;
  logic [13:0] prev_bend_q, prev_bend_d;

  // pending packet and output register
  logic        pend_vld_q, pend_vld_d;
  pkt_t        pend_q, pend_d;
  logic        out_vld_q, out_vld_d;
  pkt_t        out_q, out_d;
  logic        out_last_q, out_last_d;

  // pin table memory, {note, accent} per entry
  logic [13:0]      mem [Depth];
  logic [Depth-1:0] ent_vld_q;
  logic [13:0]      rd_q;
  logic             rd_vld_q;
  logic [PinW-1:0]  rd_addr;
  logic             tbl_we;
  logic [PinW-1:0]  wr_addr;

  logic       s_acc;
  logic [5:0] limit;
  logic [5:0] cnt_inc;
  logic       can_move;
  logic       advance;

  // walk step signals
  logic [6:0] note;
  logic [6:0] accent;
  logic [6:0] vel;
  logic       now_k;
  logic       was_k;
  logic       need_pkt;
  pkt_t       walk_pkt;

  // bend step signals
  logic signed [16:0] ty;
  logic [15:0]        t_clamp;
  logic [29:0]        prod;
  logic [13:0]        bend;
  logic               need_bend;
  pkt_t               bend_pkt;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign limit         = (count_q > 6'(Depth)) ? 6'(Depth) : count_q;
  assign cnt_inc       = cnt_q + 6'd1;
  assign can_move      = !out_vld_q || m_axis_tready;

  assign wr_addr = map_pin[PinW-1:0];
  assign tbl_we  = s_acc && cmd && ({1'b0, map_pin} < 6'(Depth));

  // edge detection for the pin under the walk
  assign note     = rd_vld_q ? rd_q[13:7] : 7'd0;
  assign accent   = rd_vld_q ? rd_q[6:0]  : 7'd0;
  assign vel      = (accent != 7'd0) ? accent : gvel_q;
  assign now_k    = keys_q[cnt_q[4:0]];
  assign was_k    = prev_keys_q[cnt_q[4:0]];
  assign need_pkt = (note != 7'd0) && (now_k != was_k);

  always_comb begin
    walk_pkt.cin    = now_k ? CinOn : CinOff;
    walk_pkt.status = (now_k ? StatusOn : StatusOff) | {4'h0, chan_q};
    walk_pkt.d1     = {1'b0, note};
    walk_pkt.d2     = {1'b0, vel};
  end

  // bend value: clamp(y + 1.0) scaled by 16383 / 32768
  assign ty = {ring_y_q[15], ring_y_q} + 17'sd16384;
  always_comb begin
    if (ty < 17'sd0) begin
      t_clamp = 16'd0;
    end else if (ty > 17'sd32768) begin
      t_clamp = 16'd32768;
    end else begin
      t_clamp = ty[15:0];
    end
  end
  assign prod      = 30'(t_clamp) * 30'(BendMax);
  assign bend      = ring_act_q ? prod[28:15] : BendCentre;
  assign need_bend = bend_en_q && (bend != prev_bend_q);

  always_comb begin
    bend_pkt.cin    = CinBend;
    bend_pkt.status = StatusBend | {4'h0, chan_q};
    bend_pkt.d1     = {1'b0, bend[6:0] & SevenBits};
    bend_pkt.d2     = {1'b0, bend[13:7] & SevenBits};
  end

  // a new packet may enter the pending slot when the slot is empty or drains out
  always_comb begin
    unique case (state_q)
      S_WALK:  advance = !need_pkt || !pend_vld_q || can_move;
      S_BEND:  advance = !need_bend || !pend_vld_q || can_move;
      default: advance = 1'b0;
    endcase
  end

  // table read address follows the walk, held while stalled
  assign rd_addr = (state_q == S_WALK && advance) ? cnt_inc[PinW-1:0] :
                   (state_q == S_WALK) ? cnt_q[PinW-1:0] : '0;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    keys_d      = keys_q;
    prev_keys_d = prev_keys_q;
    ring_act_d  = ring_act_q;
    ring_y_d    = ring_y_q;
    prev_bend_d = prev_bend_q;
    pend_vld_d  = pend_vld_q;
    pend_d      = pend_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_d       = out_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_acc && !cmd) begin
          if (!host_mounted) begin
            prev_keys_d = key_bits;
          end else begin
            keys_d     = key_bits;
            ring_act_d = ring_active;
            ring_y_d   = ring_y;
            cnt_d      = '0;
            state_d    = (limit == 6'd0) ? S_BEND : S_WALK;
          end
        end
      end
      S_WALK: begin
        if (advance) begin
          if (need_pkt) begin
            pend_d     = walk_pkt;
            pend_vld_d = 1'b1;
            if (pend_vld_q) begin
              out_d      = pend_q;
              out_last_d = 1'b0;
              out_vld_d  = 1'b1;
            end
          end
          cnt_d = cnt_inc;
          if (cnt_inc == limit) begin
            state_d = S_BEND;
          end
        end
      end
      S_BEND: begin
        if (advance) begin
          if (need_bend) begin
            pend_d      = bend_pkt;
            pend_vld_d  = 1'b1;
            prev_bend_d = bend;
            if (pend_vld_q) begin
              out_d      = pend_q;
              out_last_d = 1'b0;
              out_vld_d  = 1'b1;
            end
          end
          prev_keys_d = keys_q;
          state_d     = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // the pending packet is the final one of this scan
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (can_move) begin
          out_d      = pend_q;
          out_last_d = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      prev_keys_q <= '0;
      prev_bend_q <= BendCentre;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      ent_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prev_keys_q <= prev_keys_d;
      prev_bend_q <= prev_bend_d;
      pend_vld_q  <= pend_vld_d;
      out_vld_q   <= out_vld_d;
      if (tbl_we) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    keys_q     <= keys_d;
    ring_act_q <= ring_act_d;
    ring_y_q   <= ring_y_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  // pin table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      mem[wr_addr] <= {map_note, map_velocity};
    end
    rd_q     <= mem[rd_addr];
    rd_vld_q <= ent_vld_q[rd_addr];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

  // no packet may sit in the pending slot between scans
  a_idle_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_vld_q)
    else $error("pending packet left over after a scan");

  // the walk never runs past the eligible pins
  a_walk_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> cnt_q < limit)
    else $error("pin walk beyond note count");

  // an empty pending slot at flush returns to idle at once
  a_flush_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && !pend_vld_q) |=> state_q == S_IDLE)
    else $error("flush did not finish");

  // the stored bend changes only in the bend step
  a_bend_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(prev_bend_q) |-> $past(state_q) == S_BEND)
    else $error("previous bend changed outside the bend step");

endmodule : key_edge_midi_event_encoder

`default_nettype wire
